[rtl/lhn_pkg.sv]
`timescale 1ns / 1ps
package lhn_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NumerW = 38;
  localparam int unsigned ScaleW = 7;
  localparam int unsigned CmdW   = 3;

  localparam logic [CmdW-1:0] CmdRaw1d    = 3'd0;
  localparam logic [CmdW-1:0] CmdRaw2d    = 3'd1;
  localparam logic [CmdW-1:0] CmdRaw3d    = 3'd2;
  localparam logic [CmdW-1:0] CmdRaw4d    = 3'd3;
  localparam logic [CmdW-1:0] CmdSmooth1d = 3'd4;
  localparam logic [CmdW-1:0] CmdSmooth2d = 3'd5;
  localparam logic [CmdW-1:0] CmdSmooth3p = 3'd6;
  localparam logic [CmdW-1:0] CmdSmooth3f = 3'd7;

  // tag that travels with each lattice point through the hash pipe
  typedef struct packed {
    logic       first;
    logic       last;
    logic [3:0] weight;
    logic [6:0] scale;
  } pt_tag_t;

  function automatic logic [6:0] scale_of(input logic [CmdW-1:0] cmd);
    case (cmd)
      CmdSmooth1d:              scale_of = 7'd4;
      CmdSmooth2d, CmdSmooth3p: scale_of = 7'd16;
      CmdSmooth3f:              scale_of = 7'd96;
      default:                  scale_of = 7'd1;
    endcase
  endfunction
endpackage

[rtl/lattice_hash_noise.sv]
`timescale 1ns / 1ps
// Lattice value-noise hash. Input channel: command and x/y/z/w coordinates
// under valid_i/ready_o; output: noise_numerator and noise_scale under
// valid_o/ready_i. numerator / (scale * 2^30) is the noise value.
// Each transaction is walked point by point through one pipelined hash unit
// that takes one lattice point per cycle unless the output stalls: raw modes
// walk 1 point, smooth 1D 3, smooth 2D/planar 9, full 3D 27 per transaction.
// The last point passes the hash stages and the product register to valid_o.
// Transactions overlap in the pipe; the next one enters right behind.
// A stalled output freezes the whole pipe, nothing is lost or repeated.
// Reset clears all valid bits; points are taken right after reset, ready_o on a last point.
module lattice_hash_noise
  import lhn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [CmdW-1:0]          command_i,
  input  logic signed [CoordW-1:0] x_coord_i,
  input  logic signed [CoordW-1:0] y_coord_i,
  input  logic signed [CoordW-1:0] z_coord_i,
  input  logic signed [CoordW-1:0] w_coord_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [NumerW-1:0] noise_numerator_o,
  output logic [ScaleW-1:0]        noise_scale_o
);
  logic               adv, pv, hv;
  logic [CoordW-1:0]  mix;
  pt_tag_t            ptag, htag;
  logic signed [31:0] raw;
  logic [NumerW-1:0]  num;

  lhn_seq u_seq (
    .clk_i, .rst_ni, .valid_i, .ready_o, .command_i,
    .x_coord_i, .y_coord_i, .z_coord_i, .w_coord_i,
    .adv_i(adv), .pt_valid_o(pv), .mix_o(mix), .tag_o(ptag)
  );

  lhn_hash u_hash (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(pv), .mix_i(mix), .tag_i(ptag),
    .valid_o(hv), .raw_o(raw), .tag_o(htag)
  );

  lhn_acc u_acc (
    .clk_i, .rst_ni, .valid_i(hv), .raw_i(raw), .tag_i(htag), .adv_o(adv),
    .valid_o, .ready_i, .noise_numerator_o(num), .noise_scale_o
  );

  assign noise_numerator_o = $signed(num);
endmodule

[rtl/lhn_seq.sv]
`timescale 1ns / 1ps
// Walks the neighbor points of one transaction, one point per cycle while adv_i is high.
module lhn_seq
  import lhn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [CoordW-1:0]  x_coord_i,
  input  logic [CoordW-1:0]  y_coord_i,
  input  logic [CoordW-1:0]  z_coord_i,
  input  logic [CoordW-1:0]  w_coord_i,
  input  logic               adv_i,
  output logic               pt_valid_o,
  output logic [CoordW-1:0]  mix_o,
  output pt_tag_t            tag_o
);
  logic [1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [1:0] dx, dy, dz;
  logic [1:0] nz;
  logic [CoordW-1:0] px, py, pz, pw;
  logic       last;

  // one counter per axis, offset digit 1 = center
  always_comb begin
    dx = 2'd1;
    dy = 2'd1;
    dz = 2'd1;
    last = 1'b1;
    case (command_i)
      CmdSmooth1d: begin
        dx = cx_q;
        last = (cx_q == 2'd2);
      end
      CmdSmooth2d, CmdSmooth3p: begin
        dx = cx_q;
        dy = cy_q;
        last = (cx_q == 2'd2) && (cy_q == 2'd2);
      end
      CmdSmooth3f: begin
        dx = cx_q;
        dy = cy_q;
        dz = cz_q;
        last = (cx_q == 2'd2) && (cy_q == 2'd2) && (cz_q == 2'd2);
      end
      default: ;
    endcase
  end

  always_comb begin
    px = x_coord_i + CoordW'(dx) - CoordW'(1);
    py = '0;
    pz = '0;
    pw = '0;
    case (command_i)
      CmdRaw1d, CmdSmooth1d: ;
      CmdRaw2d, CmdSmooth2d: py = y_coord_i + CoordW'(dy) - CoordW'(1);
      CmdSmooth3p: begin
        py = y_coord_i + CoordW'(dy) - CoordW'(1);
        pz = z_coord_i;
      end
      CmdRaw4d: begin
        py = y_coord_i;
        pz = z_coord_i;
        pw = w_coord_i;
      end
      default: begin
        py = y_coord_i + CoordW'(dy) - CoordW'(1);
        pz = z_coord_i + CoordW'(dz) - CoordW'(1);
      end
    endcase
  end

  always_comb begin
    nz = 2'((dx != 2'd1)) + 2'((dy != 2'd1)) + 2'((dz != 2'd1));
    tag_o.first  = (cx_q == 2'd0) && (cy_q == 2'd0) && (cz_q == 2'd0);
    tag_o.last   = last;
    tag_o.scale  = scale_of(command_i);
    case (command_i)
      CmdSmooth1d: tag_o.weight = (nz == 2'd0) ? 4'd2 : 4'd1;
      CmdSmooth2d, CmdSmooth3p:
        tag_o.weight = (nz == 2'd0) ? 4'd4 : ((nz == 2'd1) ? 4'd2 : 4'd1);
      CmdSmooth3f:
        tag_o.weight = (nz == 2'd0) ? 4'd12 : ((nz == 2'd1) ? 4'd4 : 4'd3);
      default: tag_o.weight = 4'd1;
    endcase
  end

  // point mix feeds stage 1 of the hash
  assign mix_o = px + 32'd57 * py + 32'd131 * pz + 32'd323 * pw;
  assign pt_valid_o = valid_i;
  assign ready_o = adv_i && last;

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    if (valid_i && adv_i) begin
      if (last) begin
        cx_d = 2'd0;
        cy_d = 2'd0;
        cz_d = 2'd0;
      end else if (cx_q != 2'd2) begin
        cx_d = cx_q + 2'd1;
      end else begin
        cx_d = 2'd0;
        if (cy_q != 2'd2) begin
          cy_d = cy_q + 2'd1;
        end else begin
          cy_d = 2'd0;
          cz_d = cz_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end
endmodule

[rtl/lhn_hash.sv]
`timescale 1ns / 1ps
// Pipelined hash: h = n*(n*n*15731+789221)+1376312589 after n ^= n<<13.
module lhn_hash
  import lhn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [CoordW-1:0] mix_i,
  input  pt_tag_t           tag_i,
  output logic              valid_o,
  output logic signed [31:0] raw_o,
  output pt_tag_t           tag_o
);
  logic [3:0]        v_q;
  logic [31:0]       n1_q, n2_q, n3_q, sq_q, in_q;
  logic [31:0]       h_q;
  pt_tag_t           t1_q, t2_q, t3_q, t4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv_i) v_q <= {v_q[2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n1_q <= (mix_i << 13) ^ mix_i;
      t1_q <= tag_i;
      sq_q <= n1_q * n1_q;
      n2_q <= n1_q;
      t2_q <= t1_q;
      in_q <= sq_q * 32'd15731 + 32'd789221;
      n3_q <= n2_q;
      t3_q <= t2_q;
      h_q  <= n3_q * in_q + 32'd1376312589;
      t4_q <= t3_q;
    end
  end

  assign valid_o = v_q[3];
  assign raw_o = 32'sh4000_0000 - $signed({1'b0, h_q[30:0]});
  assign tag_o = t4_q;
endmodule

[rtl/lhn_acc.sv]
`timescale 1ns / 1ps
// Weighted accumulation with an output register.
module lhn_acc
  import lhn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] raw_i,
  input  pt_tag_t            tag_i,
  output logic               adv_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [NumerW-1:0]  noise_numerator_o,
  output logic [ScaleW-1:0]  noise_scale_o
);
  logic               pv_q;
  logic signed [35:0] prod_q;
  pt_tag_t            pt_q;
  logic signed [NumerW-1:0] acc_q, acc_d;
  logic               ov_q;
  logic [NumerW-1:0]  num_q;
  logic [ScaleW-1:0]  sc_q;

  // stall whole pipe only when a finished sum cannot be unloaded
  assign adv_o = !(ov_q && !ready_i);
  assign acc_d = (pt_q.first ? '0 : acc_q) + NumerW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv_o) begin
      pv_q <= valid_i;
      ov_q <= pv_q && pt_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      prod_q <= raw_i * $signed({1'b0, tag_i.weight});
      pt_q <= tag_i;
      if (pv_q) begin
        acc_q <= acc_d;
        if (pt_q.last) begin
          num_q <= acc_d;
          sc_q  <= pt_q.scale;
        end
      end
    end
  end

  assign valid_o = ov_q;
  assign noise_numerator_o = num_q;
  assign noise_scale_o = sc_q;

  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (noise_scale_o == 7'd1 || noise_scale_o == 7'd4 ||
                 noise_scale_o == 7'd16 || noise_scale_o == 7'd96))
    else $error("bad scale");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(noise_numerator_o)))
    else $error("output dropped");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_o |=> $stable(pt_q))
    else $error("pipe moved in stall");
endmodule

[bench/tb_lattice_hash_noise.sv]
`timescale 1ns / 1ps
module tb_lattice_hash_noise;
  import lhn_pkg::*;

  typedef struct {
    logic [CmdW-1:0]   cmd;
    logic [CoordW-1:0] x, y, z, w;
  } lattice_req_t;

  typedef struct {
    logic [NumerW-1:0] numer;
    logic [ScaleW-1:0] scale;
  } noise_res_t;

  int errors = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  class noise_scoreboard;
    noise_res_t pending[$];

    function automatic longint lattice_raw(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [31:0] w);
      logic [31:0] n, h;
      n = x + 32'd57 * y + 32'd131 * z + 32'd323 * w;
      n = (n << 13) ^ n;
      h = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      return 64'sd1073741824 - longint'({33'd0, h[30:0]});
    endfunction

    function automatic noise_res_t predict_noise(lattice_req_t r);
      noise_res_t res;
      longint sum;
      int nz;
      logic [31:0] zz;
      sum = 0;
      res.scale = 7'd1;
      case (r.cmd)
        CmdRaw1d: sum = lattice_raw(r.x, 0, 0, 0);
        CmdRaw2d: sum = lattice_raw(r.x, r.y, 0, 0);
        CmdRaw3d: sum = lattice_raw(r.x, r.y, r.z, 0);
        CmdRaw4d: sum = lattice_raw(r.x, r.y, r.z, r.w);
        CmdSmooth1d: begin
          for (int dx = -1; dx <= 1; dx++)
            sum += (dx == 0 ? 2 : 1) * lattice_raw(r.x + dx, 0, 0, 0);
          res.scale = 7'd4;
        end
        CmdSmooth2d, CmdSmooth3p: begin
          zz = (r.cmd == CmdSmooth3p) ? r.z : 32'd0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
              nz = (dx != 0) + (dy != 0);
              sum += (nz == 0 ? 4 : nz == 1 ? 2 : 1) *
                     lattice_raw(r.x + dx, r.y + dy, zz, 0);
            end
          res.scale = 7'd16;
        end
        default: begin
          for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
              for (int dx = -1; dx <= 1; dx++) begin
                nz = (dx != 0) + (dy != 0) + (dz != 0);
                sum += (nz == 0 ? 12 : nz == 1 ? 4 : 3) *
                       lattice_raw(r.x + dx, r.y + dy, r.z + dz, 0);
              end
          res.scale = 7'd96;
        end
      endcase
      res.numer = sum[NumerW-1:0];
      return res;
    endfunction

    function void note_request(lattice_req_t r);
      pending.push_back(predict_noise(r));
    endfunction

    task check_result(logic [NumerW-1:0] numer, logic [ScaleW-1:0] scale);
      noise_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result transaction");
        return;
      end
      e = pending.pop_front();
      if (numer !== e.numer)
        report_mismatch($sformatf("numerator %0h, expected %0h", numer, e.numer));
      if (scale !== e.scale)
        report_mismatch($sformatf("scale %0d, expected %0d", scale, e.scale));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic valid_in = 1'b0;
  logic ready_out;
  logic [CmdW-1:0] cmd_in = '0;
  logic signed [CoordW-1:0] x_in = '0, y_in = '0, z_in = '0, w_in = '0;
  logic valid_out;
  logic ready_in = 1'b0;
  logic signed [NumerW-1:0] numer_out;
  logic [ScaleW-1:0] scale_out;

  noise_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  lattice_hash_noise i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .valid_i(valid_in), .ready_o(ready_out),
    .command_i(cmd_in), .x_coord_i(x_in), .y_coord_i(y_in),
    .z_coord_i(z_in), .w_coord_i(w_in),
    .valid_o(valid_out), .ready_i(ready_in),
    .noise_numerator_o(numer_out), .noise_scale_o(scale_out)
  );

  // input side acceptance and output checking, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (valid_in && ready_out)
        sb.note_request('{cmd_in, x_in, y_in, z_in, w_in});
      if (valid_out && ready_in)
        sb.check_result(numer_out, scale_out);
      if ((valid_in && ready_out) || (valid_out && ready_in)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("lattice_hash_noise verification failed");
        $finish;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) ready_in <= 1'b0;
    else if (hold_off) ready_in <= 1'b0;
    else ready_in <= no_idle || ($urandom_range(99) >= 35);
  end

  // valid stays high from one transaction to the next unless an idle gap is drawn
  task automatic send_point(input lattice_req_t r);
    if (!no_idle && ($urandom_range(99) < 35)) begin
      valid_in <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    valid_in <= 1'b1;
    cmd_in <= r.cmd;
    x_in <= r.x; y_in <= r.y; z_in <= r.z; w_in <= r.w;
    do @(posedge clk); while (!ready_out);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return $urandom_range(4) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic lattice_req_t random_request();
    lattice_req_t r;
    r.cmd = CmdW'($urandom_range(7));
    r.x = pick_coord(); r.y = pick_coord();
    r.z = pick_coord(); r.w = pick_coord();
    return r;
  endfunction

  task automatic drain_results();
    valid_in <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    lattice_req_t r;
    logic [CmdW-1:0] cmds[8];
    cmds = '{CmdRaw1d, CmdRaw2d, CmdRaw3d, CmdRaw4d,
             CmdSmooth1d, CmdSmooth2d, CmdSmooth3p, CmdSmooth3f};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every command at zero, then twice with coordinates at the wrap edges and all ones
    foreach (cmds[i]) send_point('{cmds[i], 32'd0, 32'd0, 32'd0, 32'd0});
    foreach (cmds[i])
      send_point('{cmds[i], 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h7fffffff});
    foreach (cmds[i])
      send_point('{cmds[i], 32'h80000000, 32'hffffffff, 32'h7fffffff, 32'hffffffff});
    // sender pauses until the pipe is empty
    drain_results();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_point(random_request());
    join
    no_idle = 1'b1;
    for (int i = 0; i < 120; i++) send_point(random_request());
    no_idle = 1'b0;
    for (int i = 0; i < 370; i++) send_point(random_request());
    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0)
      $display("lattice_hash_noise verification clean");
    else
      $display("lattice_hash_noise verification failed");
    $finish;
  end
endmodule
